// ===== rtl/core/psrl_pkg.sv =====
// Shared types, constants and helpers for the per-source rate limiter.
// Used by psrl_ban_table, psrl_hist_table and per_source_rate_limit_ban.
package psrl_pkg;

   // Table sizes are powers of two; slot = fold16(addr) masked to the index width.
   localparam int HIST_AW      = 12;
   localparam int BAN_AW       = 12;
   localparam int HIST_ENTRIES = 1 << HIST_AW;
   localparam int BAN_ENTRIES  = 1 << BAN_AW;
   localparam int MAX_AW       = (HIST_AW > BAN_AW) ? HIST_AW : BAN_AW;
   localparam int CLR_W        = MAX_AW + 1;

   localparam logic [15:0] IPV4_TYPE      = 16'h0800;
   localparam logic [15:0] MIN_IPV4_FRAME = 16'd34;

   localparam logic [31:0] PACKET_LIMIT_RST = 32'd1000;
   localparam logic [31:0] BYTE_LIMIT_RST   = 32'd1048576;
   localparam logic [15:0] BAN_SECONDS_RST  = 16'd60;

   localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

   // CSR indexes
   localparam logic [1:0] CSR_PACKET_LIMIT = 2'd0;
   localparam logic [1:0] CSR_BYTE_LIMIT   = 2'd1;
   localparam logic [1:0] CSR_BAN_SECONDS  = 2'd2;

   typedef enum logic [1:0] {
      REASON_BYPASS  = 2'd0,
      REASON_PASS    = 2'd1,
      REASON_BANNED  = 2'd2,
      REASON_NEW_BAN = 2'd3
   } reason_type;

   typedef enum logic [2:0] {
      CLEAR_ST = 3'b001,
      IDLE_ST  = 3'b010,
      LOOK_ST  = 3'b100
   } state_type;

   typedef struct packed {
      logic [31:0] now_seconds;
      logic [31:0] source_address;
      logic [15:0] frame_length;
      logic [15:0] ethertype;
   } frame_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] key;
      logic [32:0] ban_end;
   } ban_entry_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] key;
      logic [31:0] second;
      logic [31:0] packets;
      logic [31:0] bytes;
   } hist_entry_type;

   typedef struct packed {
      logic hit;      // valid entry with matching key
      logic active;   // ban end still in the future
   } ban_stat_type;

   typedef struct packed {
      logic fresh;    // new source or new second: window restarts
      logic over;     // a count exceeds its limit after this frame
   } hist_stat_type;

   function automatic logic [15:0] fold16(input logic [31:0] a);
      fold16 = a[15:0] ^ a[31:16];
   endfunction

endpackage

// ===== rtl/core/psrl_ban_table.sv =====
// Ban table: synchronous RAM of ban entries plus the hit / expiry check.
// Depends on psrl_pkg.
module psrl_ban_table (
   input  logic                         clock,
   input  logic                         rd_en,
   input  logic [psrl_pkg::BAN_AW-1:0]  rd_idx,
   input  logic                         wr_en,
   input  logic [psrl_pkg::BAN_AW-1:0]  wr_idx,
   input  psrl_pkg::ban_entry_type      wr_data,
   input  logic [31:0]                  source_address,
   input  logic [31:0]                  now_seconds,
   output psrl_pkg::ban_stat_type       stat
);

   psrl_pkg::ban_entry_type mem [psrl_pkg::BAN_ENTRIES];
   psrl_pkg::ban_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   always_comb begin
      stat.hit    = rd_data_ff.valid && (rd_data_ff.key == source_address);
      stat.active = rd_data_ff.ban_end > {1'b0, now_seconds};
   end

endmodule

// ===== rtl/core/psrl_hist_table.sv =====
// History table: synchronous RAM of per-source one-second counts and the
// saturating count update with limit compare. Depends on psrl_pkg.
module psrl_hist_table (
   input  logic                         clock,
   input  logic                         rd_en,
   input  logic [psrl_pkg::HIST_AW-1:0] rd_idx,
   input  logic                         wr_en,
   input  logic [psrl_pkg::HIST_AW-1:0] wr_idx,
   input  logic                         clr_en,
   input  psrl_pkg::frame_type          frame,
   input  logic [31:0]                  packet_limit,
   input  logic [31:0]                  byte_limit,
   output psrl_pkg::hist_stat_type      stat
);

   psrl_pkg::hist_entry_type mem [psrl_pkg::HIST_ENTRIES];
   psrl_pkg::hist_entry_type rd_data_ff;
   psrl_pkg::hist_entry_type upd;
   psrl_pkg::hist_entry_type wr_data;
   logic [32:0]              pkt_sum;
   logic [32:0]              byte_sum;
   logic [31:0]              pkt_sat;
   logic [31:0]              byte_sat;

   always_comb begin
      stat.fresh = !rd_data_ff.valid
                   || (rd_data_ff.key != frame.source_address)
                   || (rd_data_ff.second != frame.now_seconds);

      pkt_sum  = {1'b0, rd_data_ff.packets} + 33'd1;
      byte_sum = {1'b0, rd_data_ff.bytes} + {17'd0, frame.frame_length};
      pkt_sat  = pkt_sum[32]  ? psrl_pkg::MAX32 : pkt_sum[31:0];
      byte_sat = byte_sum[32] ? psrl_pkg::MAX32 : byte_sum[31:0];

      stat.over = (pkt_sat > packet_limit) || (byte_sat > byte_limit);

      upd.valid  = 1'b1;
      upd.key    = frame.source_address;
      upd.second = frame.now_seconds;
      if (stat.fresh) begin
         upd.packets = 32'd1;
         upd.bytes   = {16'd0, frame.frame_length};
      end else begin
         upd.packets = pkt_sat;
         upd.bytes   = byte_sat;
      end

      wr_data = upd;
      if (clr_en) begin
         wr_data.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

endmodule

// ===== rtl/core/per_source_rate_limit_ban.sv =====
// Per-source rate limiter with timed ban: one verdict per received frame.
// Flow: an accepted request starts both table reads; the lookup state then writes
// back and registers the verdict once the response slot is free; no new frame till then.
// Reset: synchronous; CSRs take their defaults and a clearing pass walks every
// slot of both tables (4096, the larger table depth), request side held not ready.
module per_source_rate_limit_ban (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // [15:0] ethertype, [31:16] frame_length, [63:32] source_address,
   // [95:64] now_seconds
   input  logic [95:0] req_tdata,
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] drop, [2:1] verdict_reason, [7:3] zero
   output logic [7:0]  rsp_tdata,
   // configuration
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [31:0] packet_limit_ff, packet_limit_in;
   logic [31:0] byte_limit_ff, byte_limit_in;
   logic [15:0] ban_seconds_ff, ban_seconds_in;

   always_comb begin
      packet_limit_in = packet_limit_ff;
      byte_limit_in   = byte_limit_ff;
      ban_seconds_in  = ban_seconds_ff;
      if (csr_wr_en) begin
         case (csr_index)
            psrl_pkg::CSR_PACKET_LIMIT: packet_limit_in = csr_wdata;
            psrl_pkg::CSR_BYTE_LIMIT:   byte_limit_in   = csr_wdata;
            psrl_pkg::CSR_BAN_SECONDS:  ban_seconds_in  = csr_wdata[15:0];
            default: ;   // unmapped index, ignored
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Control: clear sweep, idle, lookup/write-back
   // ---------------------------------------------------------------------
   psrl_pkg::state_type            state_ff, state_in;
   logic [psrl_pkg::CLR_W-1:0]     clr_cnt_ff, clr_cnt_in;
   psrl_pkg::frame_type            frame_ff, frame_in;
   psrl_pkg::frame_type            req_frame;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           drop_ff, drop_in;
   psrl_pkg::reason_type           reason_ff, reason_in;

   psrl_pkg::ban_stat_type         ban_stat;
   psrl_pkg::hist_stat_type        hist_stat;

   logic        accept;
   logic        clearing;
   logic        finish;        // lookup cycle that commits its verdict
   logic        is_ipv4;
   logic        banned;
   logic        new_ban;
   logic [15:0] req_fold;
   logic [15:0] cur_fold;
   logic [32:0] ban_end_new;

   // ban table port
   logic                          ban_wr_en;
   logic [psrl_pkg::BAN_AW-1:0]   ban_wr_idx;
   psrl_pkg::ban_entry_type       ban_wr_data;

   // history table port
   logic                          hist_wr_en;
   logic [psrl_pkg::HIST_AW-1:0]  hist_wr_idx;

   assign req_frame  = req_tdata;
   assign req_tready = (state_ff == psrl_pkg::IDLE_ST);
   assign accept     = req_tvalid && req_tready;
   assign clearing   = (state_ff == psrl_pkg::CLEAR_ST);

   // result slot is free when empty or being emptied this cycle
   assign finish = (state_ff == psrl_pkg::LOOK_ST) && (!rsp_valid_ff || rsp_tready);

   assign req_fold = psrl_pkg::fold16(req_frame.source_address);
   assign cur_fold = psrl_pkg::fold16(frame_ff.source_address);

   assign is_ipv4 = (frame_ff.ethertype == psrl_pkg::IPV4_TYPE)
                    && (frame_ff.frame_length >= psrl_pkg::MIN_IPV4_FRAME);
   assign banned  = ban_stat.hit && ban_stat.active;
   // only a repeat frame inside the same second can trip the limits
   assign new_ban = is_ipv4 && !banned && !hist_stat.fresh && hist_stat.over;

   assign ban_end_new = {1'b0, frame_ff.now_seconds} + {17'd0, ban_seconds_ff};

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      frame_in     = frame_ff;
      rsp_valid_in = rsp_valid_ff;
      drop_in      = drop_ff;
      reason_in    = reason_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         psrl_pkg::CLEAR_ST: begin
            clr_cnt_in = clr_cnt_ff + psrl_pkg::CLR_W'(1);
            if (clr_cnt_ff == psrl_pkg::CLR_W'((1 << psrl_pkg::MAX_AW) - 1)) begin
               state_in = psrl_pkg::IDLE_ST;
            end
         end
         psrl_pkg::IDLE_ST: begin
            if (accept) begin
               frame_in = req_frame;
               state_in = psrl_pkg::LOOK_ST;
            end
         end
         psrl_pkg::LOOK_ST: begin
            if (finish) begin
               rsp_valid_in = 1'b1;
               state_in     = psrl_pkg::IDLE_ST;
               if (!is_ipv4) begin
                  drop_in   = 1'b0;
                  reason_in = psrl_pkg::REASON_BYPASS;
               end else if (banned) begin
                  drop_in   = 1'b1;
                  reason_in = psrl_pkg::REASON_BANNED;
               end else if (new_ban) begin
                  drop_in   = 1'b1;
                  reason_in = psrl_pkg::REASON_NEW_BAN;
               end else begin
                  drop_in   = 1'b0;
                  reason_in = psrl_pkg::REASON_PASS;
               end
            end
         end
         default: begin
            state_in = psrl_pkg::IDLE_ST;
         end
      endcase
   end

   // Ban write-back: clear sweep, expiry of a matching ban, or a new ban.
   // A new ban and an expiry clear hit the same slot; the new ban wins.
   always_comb begin
      ban_wr_idx          = cur_fold[psrl_pkg::BAN_AW-1:0];
      ban_wr_data.valid   = new_ban;
      ban_wr_data.key     = frame_ff.source_address;
      ban_wr_data.ban_end = ban_end_new;
      ban_wr_en           = finish && is_ipv4 && !banned && (ban_stat.hit || new_ban);
      if (clearing) begin
         ban_wr_idx        = clr_cnt_ff[psrl_pkg::BAN_AW-1:0];
         ban_wr_data.valid = 1'b0;
         ban_wr_en         = clr_cnt_ff < psrl_pkg::CLR_W'(psrl_pkg::BAN_ENTRIES);
      end
   end

   // History write-back: clear sweep, or every IPv4 frame that is not under an active ban.
   always_comb begin
      hist_wr_idx = cur_fold[psrl_pkg::HIST_AW-1:0];
      hist_wr_en  = finish && is_ipv4 && !banned;
      if (clearing) begin
         hist_wr_idx = clr_cnt_ff[psrl_pkg::HIST_AW-1:0];
         hist_wr_en  = clr_cnt_ff < psrl_pkg::CLR_W'(psrl_pkg::HIST_ENTRIES);
      end
   end

   psrl_ban_table u_ban (
      .clock          (clock),
      .rd_en          (accept),
      .rd_idx         (req_fold[psrl_pkg::BAN_AW-1:0]),
      .wr_en          (ban_wr_en),
      .wr_idx         (ban_wr_idx),
      .wr_data        (ban_wr_data),
      .source_address (frame_ff.source_address),
      .now_seconds    (frame_ff.now_seconds),
      .stat           (ban_stat)
   );

   psrl_hist_table u_hist (
      .clock        (clock),
      .rd_en        (accept),
      .rd_idx       (req_fold[psrl_pkg::HIST_AW-1:0]),
      .wr_en        (hist_wr_en),
      .wr_idx       (hist_wr_idx),
      .clr_en       (clearing),
      .frame        (frame_ff),
      .packet_limit (packet_limit_ff),
      .byte_limit   (byte_limit_ff),
      .stat         (hist_stat)
   );

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= psrl_pkg::CLEAR_ST;
         clr_cnt_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
         packet_limit_ff <= psrl_pkg::PACKET_LIMIT_RST;
         byte_limit_ff   <= psrl_pkg::BYTE_LIMIT_RST;
         ban_seconds_ff  <= psrl_pkg::BAN_SECONDS_RST;
      end else begin
         state_ff        <= state_in;
         clr_cnt_ff      <= clr_cnt_in;
         rsp_valid_ff    <= rsp_valid_in;
         packet_limit_ff <= packet_limit_in;
         byte_limit_ff   <= byte_limit_in;
         ban_seconds_ff  <= ban_seconds_in;
      end
   end

   // payload: no reset
   always_ff @(posedge clock) begin
      frame_ff  <= frame_in;
      drop_ff   <= drop_in;
      reason_ff <= reason_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, reason_ff, drop_ff};

endmodule
